@@ hdl/border_connected_region_fill_assert.svh @@
// assertion macros shared by the fill block
`ifndef BORDER_CONNECTED_REGION_FILL_ASSERT_SVH
`define BORDER_CONNECTED_REGION_FILL_ASSERT_SVH

// same-cycle implication
`define BCRF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fill block check failed");

// next-cycle implication
`define BCRF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fill block check failed");

`endif

@@ hdl/bcrf_pkg.sv @@
package bcrf_pkg;

   localparam int ROW_W   = 32;  // bits of one grid row
   localparam int CFG_W   = 6;   // bits of a count register
   localparam int CMP_W   = 7;   // counts compared against the size limits
   localparam int IDX_W   = 6;   // row index over the whole row limit
   localparam int RNUM_W  = 5;   // bits of the emitted row number
   localparam int CSR_A_W = 2;

   localparam logic [CSR_A_W-1:0] CSR_ROW_COUNT    = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_COLUMN_COUNT = 2'd1;

   localparam logic [CFG_W-1:0] ROW_COUNT_RESET    = 6'd32;
   localparam logic [CFG_W-1:0] COLUMN_COUNT_RESET = 6'd32;

   // broadcast from the sequencer to every cell of the chain
   typedef struct packed {
      logic             load;
      logic             seed;
      logic             grow;
      logic             shift;
      logic [IDX_W-1:0] load_row;
      logic [IDX_W-1:0] last_row;
      logic [ROW_W-1:0] edge_bits;
      logic [ROW_W-1:0] row_data;
   } ctl_type;

endpackage

@@ hdl/bcrf_cell.sv @@
module bcrf_cell #(
   parameter int IDX = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  bcrf_pkg::ctl_type         ctl,
   input  logic [bcrf_pkg::ROW_W-1:0] up_reach,
   input  logic [bcrf_pkg::ROW_W-1:0] down_reach,
   output logic [bcrf_pkg::ROW_W-1:0] reach,
   output logic                      changed
);

   logic [bcrf_pkg::ROW_W-1:0] open_ff, open_in;
   logic [bcrf_pkg::ROW_W-1:0] reach_ff, reach_in;
   logic                       chg_ff, chg_in;
   logic [bcrf_pkg::ROW_W-1:0] grow;
   logic                       in_use;
   logic                       border_row;

   assign in_use     = ctl.last_row >= bcrf_pkg::IDX_W'(IDX);
   assign border_row = (IDX == 0) || (ctl.last_row == bcrf_pkg::IDX_W'(IDX));

   // one step of 4-neighbor growth, limited to open cells
   assign grow = ((reach_ff | (reach_ff << 1) | (reach_ff >> 1) | up_reach | down_reach)
                  & open_ff) | reach_ff;

   always_comb begin
      open_in  = open_ff;
      reach_in = reach_ff;
      chg_in   = chg_ff;
      if (ctl.load && (ctl.load_row == bcrf_pkg::IDX_W'(IDX))) begin
         open_in = ctl.row_data;
      end
      if (ctl.seed) begin
         chg_in = 1'b1;
         if (!in_use) begin
            reach_in = '0;
         end else if (border_row) begin
            reach_in = open_ff;
         end else begin
            reach_in = open_ff & ctl.edge_bits;
         end
      end else if (ctl.grow) begin
         if (in_use) begin
            reach_in = grow;
            chg_in   = grow != reach_ff;
         end else begin
            chg_in = 1'b0;
         end
      end else if (ctl.shift) begin
         reach_in = down_reach;
      end
   end

   always_ff @(posedge clock) begin
      open_ff  <= open_in;
      reach_ff <= reach_in;
      if (reset) begin
         chg_ff <= 1'b0;
      end else begin
         chg_ff <= chg_in;
      end
   end

   assign reach   = reach_ff;
   assign changed = chg_ff;

endmodule

@@ hdl/border_connected_region_fill.sv @@
// a grid of n rows loads at one request per cycle while req_valid is held, then a seed step,
// then growth steps until a step changes no row, then n results paced by rsp_ready.
// a new grid is taken only after the last result; the growth loop over the row chain
// sets the fill time, each cycle moving the reached set one step in every direction.
// reset (synchronous, active high): counts return to 32 rows and 32 columns, loading
// restarts at row 0, no result is pending.
module border_connected_region_fill #(
   parameter int MAX_ROWS    = 32,
   parameter int MAX_COLUMNS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel, one grid row per request
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [bcrf_pkg::ROW_W-1:0]    req_row_cells,
   // result channel, one filled row per result
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bcrf_pkg::RNUM_W-1:0]   rsp_row_number,
   output logic [bcrf_pkg::ROW_W-1:0]    rsp_row_result,
   output logic                          rsp_final_row,
   // register writes
   input  logic                          csr_write_enable,
   input  logic [bcrf_pkg::CSR_A_W-1:0]  csr_index,
   input  logic [bcrf_pkg::CFG_W-1:0]    csr_write_data
);

`include "border_connected_region_fill_assert.svh"

   localparam int CNT_W = $clog2(MAX_ROWS + 1);

   localparam logic [1:0] ST_LOAD = 2'd0;
   localparam logic [1:0] ST_SEED = 2'd1;
   localparam logic [1:0] ST_GROW = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]                  state_ff, state_in;
   logic [bcrf_pkg::CFG_W-1:0]  row_count_ff, row_count_in;
   logic [bcrf_pkg::CFG_W-1:0]  column_count_ff, column_count_in;
   logic [CNT_W-1:0]            rows_loaded_ff, rows_loaded_in;
   logic [CNT_W-1:0]            emit_ff, emit_in;

   logic [bcrf_pkg::CMP_W-1:0]  rows_clamped;
   logic [bcrf_pkg::CMP_W-1:0]  cols_clamped;
   logic [CNT_W-1:0]            n_rows;
   logic [bcrf_pkg::ROW_W-1:0]  col_mask;
   logic [bcrf_pkg::ROW_W-1:0]  edge_bits;
   logic                        req_fire, rsp_fire;
   logic                        grid_full, emit_last;
   logic                        any_change;
   bcrf_pkg::ctl_type           ctl;

   logic [bcrf_pkg::ROW_W-1:0]  reach_w [MAX_ROWS];
   logic [MAX_ROWS-1:0]         chg_w;

   // counts clamped into 1..limit
   always_comb begin
      rows_clamped = {1'b0, row_count_ff};
      if (rows_clamped == '0) begin
         rows_clamped = bcrf_pkg::CMP_W'(1);
      end else if (rows_clamped > bcrf_pkg::CMP_W'(MAX_ROWS)) begin
         rows_clamped = bcrf_pkg::CMP_W'(MAX_ROWS);
      end
      cols_clamped = {1'b0, column_count_ff};
      if (cols_clamped == '0) begin
         cols_clamped = bcrf_pkg::CMP_W'(1);
      end else if (cols_clamped > bcrf_pkg::CMP_W'(MAX_COLUMNS)) begin
         cols_clamped = bcrf_pkg::CMP_W'(MAX_COLUMNS);
      end
   end

   assign n_rows = CNT_W'(rows_clamped);

   // columns in use and the left/right border columns
   // a right border beyond the row width seeds nothing
   always_comb begin
      if (cols_clamped >= bcrf_pkg::CMP_W'(bcrf_pkg::ROW_W)) begin
         col_mask = '1;
      end else begin
         col_mask = (bcrf_pkg::ROW_W'(1) << cols_clamped) - bcrf_pkg::ROW_W'(1);
      end
      edge_bits = bcrf_pkg::ROW_W'(1);
      if (cols_clamped <= bcrf_pkg::CMP_W'(bcrf_pkg::ROW_W)) begin
         edge_bits = edge_bits | (bcrf_pkg::ROW_W'(1) << (cols_clamped - bcrf_pkg::CMP_W'(1)));
      end
   end

   assign req_ready = state_ff == ST_LOAD;
   assign rsp_valid = state_ff == ST_EMIT;
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;

   assign grid_full = ((CNT_W + 1)'(rows_loaded_ff) + (CNT_W + 1)'(1)) == (CNT_W + 1)'(n_rows);
   assign emit_last = ((CNT_W + 1)'(emit_ff) + (CNT_W + 1)'(1)) == (CNT_W + 1)'(n_rows);
   assign any_change = |chg_w;

   // control broadcast to the row chain
   always_comb begin
      ctl.load      = req_fire;
      ctl.seed      = state_ff == ST_SEED;
      ctl.grow      = state_ff == ST_GROW;
      ctl.shift     = rsp_fire;
      ctl.load_row  = bcrf_pkg::IDX_W'(rows_loaded_ff);
      ctl.last_row  = bcrf_pkg::IDX_W'(rows_clamped - bcrf_pkg::CMP_W'(1));
      ctl.edge_bits = edge_bits;
      ctl.row_data  = req_row_cells & col_mask;
   end

   // sequencer
   always_comb begin
      state_in        = state_ff;
      row_count_in    = row_count_ff;
      column_count_in = column_count_ff;
      rows_loaded_in  = rows_loaded_ff;
      emit_in         = emit_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (grid_full) begin
                  rows_loaded_in = '0;
                  state_in       = ST_SEED;
               end else begin
                  rows_loaded_in = rows_loaded_ff + CNT_W'(1);
               end
            end
         end
         ST_SEED: begin
            state_in = ST_GROW;
         end
         ST_GROW: begin
            // previous step left every row unchanged: the fill is complete
            if (!any_change) begin
               emit_in  = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_fire) begin
               emit_in = emit_ff + CNT_W'(1);
               if (emit_last) begin
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
      // a write to either count register restarts loading at row 0
      if (csr_write_enable) begin
         unique case (csr_index)
            bcrf_pkg::CSR_ROW_COUNT: begin
               row_count_in   = csr_write_data;
               rows_loaded_in = '0;
            end
            bcrf_pkg::CSR_COLUMN_COUNT: begin
               column_count_in = csr_write_data;
               rows_loaded_in  = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      emit_ff <= emit_in;
      if (reset) begin
         state_ff        <= ST_LOAD;
         row_count_ff    <= bcrf_pkg::ROW_COUNT_RESET;
         column_count_ff <= bcrf_pkg::COLUMN_COUNT_RESET;
         rows_loaded_ff  <= '0;
      end else begin
         state_ff        <= state_in;
         row_count_ff    <= row_count_in;
         column_count_ff <= column_count_in;
         rows_loaded_ff  <= rows_loaded_in;
      end
   end

   // one cell per grid row; reached bits pass to the rows above and below,
   // and during output the rows shift down toward cell 0
   for (genvar r = 0; r < MAX_ROWS; r++) begin : g_row
      logic [bcrf_pkg::ROW_W-1:0] up_w, down_w;
      if (r == 0) begin : g_top
         assign up_w = '0;
      end else begin : g_mid_up
         assign up_w = reach_w[r-1];
      end
      if (r == MAX_ROWS - 1) begin : g_bottom
         assign down_w = '0;
      end else begin : g_mid_down
         assign down_w = reach_w[r+1];
      end
      bcrf_cell #(
         .IDX (r)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .up_reach   (up_w),
         .down_reach (down_w),
         .reach      (reach_w[r]),
         .changed    (chg_w[r])
      );
   end

   // result comes straight from the head of the chain
   assign rsp_row_number = bcrf_pkg::RNUM_W'(emit_ff);
   assign rsp_row_result = reach_w[0];
   assign rsp_final_row  = emit_last;

   `BCRF_ASSERT_NEXT(a_last_row_done, clock, reset, rsp_fire && rsp_final_row, state_ff == ST_LOAD)
   `BCRF_ASSERT_NEXT(a_rows_in_order, clock, reset, rsp_fire && !rsp_final_row, rsp_valid && (rsp_row_number == $past(rsp_row_number) + bcrf_pkg::RNUM_W'(1)))
   `BCRF_ASSERT_NEXT(a_seed_then_grow, clock, reset, state_ff == ST_SEED, state_ff == ST_GROW)
   `BCRF_ASSERT_NEXT(a_full_grid_seeds, clock, reset, req_fire && grid_full && !csr_write_enable, state_ff == ST_SEED)
   `BCRF_ASSERT_NOW(a_sides_exclusive, clock, reset, req_ready, !rsp_valid)

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

   localparam int MAX_ROWS       = 32;
   localparam int MAX_COLUMNS    = 32;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int ITEM_TARGET    = 460;
   localparam int SETTLE_CYCLES  = 40;   // covers a partial load still in flight
   localparam int END_DRAIN      = 300;
   localparam int LONG_HOLD      = 500;
   localparam int MISMATCH_SHOWN = 10;

   // kinds of grid content used by the stimulus
   typedef enum int {
      SHAPE_NOISE,
      SHAPE_DENSE,
      SHAPE_SPARSE,
      SHAPE_FRAMED,
      SHAPE_MAZE,
      SHAPE_SOLID
   } shape_type;

   // one filled row as the block should emit it
   typedef struct packed {
      logic [bcrf_pkg::RNUM_W-1:0] row_number;
      logic [bcrf_pkg::ROW_W-1:0]  row_result;
      logic                        final_row;
   } filled_row_type;

   logic                          clock;
   logic                          reset            = 1'b1;
   logic                          req_valid        = 1'b0;
   logic                          req_ready;
   logic [bcrf_pkg::ROW_W-1:0]    req_row_cells    = '0;
   logic                          rsp_valid;
   logic                          rsp_ready        = 1'b0;
   logic [bcrf_pkg::RNUM_W-1:0]   rsp_row_number;
   logic [bcrf_pkg::ROW_W-1:0]    rsp_row_result;
   logic                          rsp_final_row;
   logic                          csr_write_enable = 1'b0;
   logic [bcrf_pkg::CSR_A_W-1:0]  csr_index        = '0;
   logic [bcrf_pkg::CFG_W-1:0]    csr_write_data   = '0;

   border_connected_region_fill u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_row_cells    (req_row_cells),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_row_number   (rsp_row_number),
      .rsp_row_result   (rsp_row_result),
      .rsp_final_row    (rsp_final_row),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // rows waiting to be offered, and filled rows waiting to come out
   logic [bcrf_pkg::ROW_W-1:0] pending_rows[$];
   filled_row_type             expected_rows[$];

   // shadow of the block's grid state and count registers
   logic [bcrf_pkg::ROW_W-1:0] shadow_grid[MAX_ROWS];
   logic [bcrf_pkg::ROW_W-1:0] shadow_reached[MAX_ROWS];
   int                         shadow_rows_loaded;
   logic [bcrf_pkg::CFG_W-1:0] shadow_row_count;
   logic [bcrf_pkg::CFG_W-1:0] shadow_col_count;

   int pushed_count    = 0;
   int accepted_count  = 0;
   int results_checked = 0;
   int grids_filled    = 0;
   int settings_count  = 0;
   int mismatch_count  = 0;
   int cycle_count     = 0;

   // clock and the single reset at the start
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // watchdog: a hung handshake or a missing result ends here
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d rows still expected",
               cycle_count, expected_rows.size());
      $display("*** FAILED ***");
      $finish;
   end

   // count registers outside 1..limit act as the nearest end of the range
   function automatic int effective_count(input logic [bcrf_pkg::CFG_W-1:0] raw, input int top);
      if (raw == 0) return 1;
      if (int'(raw) > top) return top;
      return int'(raw);
   endfunction

   function automatic logic [bcrf_pkg::ROW_W-1:0] col_mask(input int cols);
      if (cols >= bcrf_pkg::ROW_W) return '1;
      return (32'h1 << cols) - 32'h1;
   endfunction

   // grow the reached set from the open border cells until it settles
   function automatic void flood_from_border(input int n, input int cols);
      logic [bcrf_pkg::ROW_W-1:0] edge_cols;
      logic [bcrf_pkg::ROW_W-1:0] cur;
      logic [bcrf_pkg::ROW_W-1:0] grow;
      bit                         changed;
      int                         r;
      edge_cols = 32'h1 | (32'h1 << (cols - 1));
      for (r = 0; r < MAX_ROWS; r++) shadow_reached[r] = '0;
      // top and bottom rows are border everywhere, others only at the left and right edge columns
      for (r = 0; r < n; r++) begin
         if (r == 0 || r == n - 1) shadow_reached[r] = shadow_grid[r];
         else shadow_reached[r] = shadow_grid[r] & edge_cols;
      end
      changed = 1'b1;
      while (changed) begin
         changed = 1'b0;
         for (r = 0; r < n; r++) begin
            cur  = shadow_reached[r];
            grow = cur | (cur << 1) | (cur >> 1);
            if (r > 0) grow |= shadow_reached[r - 1];
            if (r + 1 < n) grow |= shadow_reached[r + 1];
            grow = (grow & shadow_grid[r]) | cur;
            if (grow != cur) begin
               shadow_reached[r] = grow;
               changed = 1'b1;
            end
         end
      end
   endfunction

   // store one accepted request; a completed grid yields one result per row
   function automatic void predict_row(input logic [bcrf_pkg::ROW_W-1:0] cells);
      int             n;
      int             cols;
      int             k;
      filled_row_type fill_row;
      n    = effective_count(shadow_row_count, MAX_ROWS);
      cols = effective_count(shadow_col_count, MAX_COLUMNS);
      if (shadow_rows_loaded >= n) shadow_rows_loaded = 0;
      shadow_grid[shadow_rows_loaded] = cells & col_mask(cols);
      shadow_rows_loaded++;
      if (shadow_rows_loaded == n) begin
         flood_from_border(n, cols);
         for (k = 0; k < n; k++) begin
            fill_row.row_number = k[bcrf_pkg::RNUM_W-1:0];
            fill_row.row_result = shadow_reached[k];
            fill_row.final_row  = (k == n - 1);
            expected_rows.push_back(fill_row);
         end
         shadow_rows_loaded = 0;
         grids_filled++;
      end
   endfunction

   // shadow state follows register writes and accepted requests
   always @(posedge clock) begin
      if (reset) begin
         shadow_rows_loaded = 0;
         shadow_row_count   = bcrf_pkg::ROW_COUNT_RESET;
         shadow_col_count   = bcrf_pkg::COLUMN_COUNT_RESET;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               bcrf_pkg::CSR_ROW_COUNT: begin
                  shadow_row_count   = csr_write_data;
                  shadow_rows_loaded = 0;
               end
               bcrf_pkg::CSR_COLUMN_COUNT: begin
                  shadow_col_count   = csr_write_data;
                  shadow_rows_loaded = 0;
               end
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            predict_row(req_row_cells);
            accepted_count++;
         end
      end
   end

   // idle length: mostly none or short, now and then a long one
   function automatic int pick_idle_len(input bit steady);
      int k;
      if (steady) return 0;
      k = $urandom_range(0, 99);
      if (k < 60) return 0;
      if (k < 88) return $urandom_range(1, 3);
      if (k < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // request driver, fed from pending_rows
   int send_gap    = 0;
   int send_steady = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else if (!req_valid || req_ready) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap  <= send_gap - 1;
         end else if (pending_rows.size() > 0) begin
            req_valid     <= 1'b1;
            req_row_cells <= pending_rows.pop_front();
            // occasional stretch of back-to-back requests
            if (send_steady > 0) send_steady <= send_steady - 1;
            else if ($urandom_range(0, 49) == 0) send_steady <= $urandom_range(30, 80);
            send_gap <= pick_idle_len(send_steady > 0);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver with random stalls and one long hold-off
   int  recv_gap    = 0;
   int  recv_steady = 0;
   int  hold_left   = 0;
   bit  hold_done   = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap  <= 0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && rsp_valid && pending_rows.size() > 20) begin
         // sender still has plenty queued: let the block back up into its input
         rsp_ready <= 1'b0;
         hold_left <= LONG_HOLD;
         hold_done <= 1'b1;
      end else if (recv_gap > 0) begin
         rsp_ready <= 1'b0;
         recv_gap  <= recv_gap - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (recv_steady > 0) recv_steady <= recv_steady - 1;
         else if ($urandom_range(0, 49) == 0) recv_steady <= $urandom_range(30, 80);
         recv_gap <= pick_idle_len(recv_steady > 0);
      end
   end

   // result monitor: compare against the oldest expected row
   filled_row_type want;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rows.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MISMATCH_SHOWN)
               $display("unexpected result: row %0d result %h final %0d",
                        rsp_row_number, rsp_row_result, rsp_final_row);
         end else begin
            want = expected_rows.pop_front();
            results_checked++;
            if (rsp_row_number !== want.row_number || rsp_row_result !== want.row_result ||
                rsp_final_row !== want.final_row) begin
               mismatch_count++;
               if (mismatch_count <= MISMATCH_SHOWN)
                  $display("mismatch at result %0d: expected row %0d %h final %0d, got row %0d %h final %0d",
                           results_checked, want.row_number, want.row_result, want.final_row,
                           rsp_row_number, rsp_row_result, rsp_final_row);
            end
         end
      end
   end

   // stimulus helpers
   task automatic queue_row(input logic [bcrf_pkg::ROW_W-1:0] cells);
      pending_rows.push_back(cells);
      pushed_count++;
   endtask

   task automatic write_register(input logic [bcrf_pkg::CSR_A_W-1:0] idx,
                                 input logic [bcrf_pkg::CFG_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // every request accepted, every result out, then let the block settle
   task automatic wait_for_idle();
      wait (accepted_count == pushed_count && expected_rows.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic shape_type pick_shape(input int n, input int cols);
      int k;
      k = $urandom_range(0, 99);
      if (k < 20) return SHAPE_DENSE;
      if (k < 35) return SHAPE_SPARSE;
      if (k < 55) return (n >= 5 && cols >= 5) ? SHAPE_FRAMED : SHAPE_NOISE;
      if (k < 70) return (n >= 4 && cols >= 4) ? SHAPE_MAZE : SHAPE_DENSE;
      if (k < 78) return SHAPE_SOLID;
      return SHAPE_NOISE;
   endfunction

   // one row of a grid of the given shape; bits above the columns get junk
   function automatic logic [bcrf_pkg::ROW_W-1:0] grid_row(input shape_type shape, input int r,
                                                           input int n, input int cols);
      logic [bcrf_pkg::ROW_W-1:0] cm;
      logic [bcrf_pkg::ROW_W-1:0] row;
      cm = col_mask(cols);
      case (shape)
         SHAPE_DENSE:  row = $urandom | $urandom;
         SHAPE_SPARSE: row = $urandom & $urandom;
         SHAPE_FRAMED: begin
            // random border, a closed wall one cell in, random enclosed interior
            if (r == 0 || r == n - 1) row = $urandom;
            else if (r == 1 || r == n - 2) row = $urandom & (32'h1 | (32'h1 << (cols - 1)));
            else row = $urandom & ~(32'h2 | (32'h1 << (cols - 2)));
         end
         SHAPE_MAZE: begin
            // single gate in the top row opens into a serpentine, long fill path
            if (r == 0) row = 32'h2;
            else if (r == n - 1) row = '0;
            else if (r % 2 == 1) row = cm & ~(32'h1 | (32'h1 << (cols - 1)));
            else if ((r / 2) % 2 == 1) row = 32'h1 << (cols - 2);
            else row = 32'h2;
            if ($urandom_range(0, 15) == 0) row ^= 32'h1 << $urandom_range(0, cols - 1);
         end
         SHAPE_SOLID:  row = $urandom_range(0, 1) ? '1 : '0;
         default:      row = $urandom;
      endcase
      if (shape != SHAPE_NOISE) row = (row & cm) | ($urandom & ~cm);
      return row;
   endfunction

   task automatic queue_grid(input shape_type shape, input int n, input int cols);
      int r;
      for (r = 0; r < n; r++) queue_row(grid_row(shape, r, n, cols));
   endtask

   task automatic apply_counts(input logic [bcrf_pkg::CFG_W-1:0] rows,
                               input logic [bcrf_pkg::CFG_W-1:0] cols);
      if ($urandom_range(0, 1)) begin
         write_register(bcrf_pkg::CSR_ROW_COUNT, rows);
         write_register(bcrf_pkg::CSR_COLUMN_COUNT, cols);
      end else begin
         write_register(bcrf_pkg::CSR_COLUMN_COUNT, cols);
         write_register(bcrf_pkg::CSR_ROW_COUNT, rows);
      end
      settings_count++;
   endtask

   // sequencer: directed grids, pressure phase, then random phases
   initial begin : stimulus
      logic [bcrf_pkg::CFG_W-1:0] raw_rows;
      logic [bcrf_pkg::CFG_W-1:0] raw_cols;
      int                         k;
      int                         n;
      int                         cols;
      int                         grid_total;
      int                         partial;

      wait (reset == 1'b0);
      @(posedge clock);

      // partial grid under the reset sizes, dropped by the next register write
      queue_row(32'hFFFFFFFF);
      queue_row(32'h00000000);
      queue_row(32'h80000001);
      wait_for_idle();

      // 5x5 with one open cell walled off in the middle, junk above column 4
      apply_counts(6'd5, 6'd5);
      queue_row(32'hFFFFFFFF);
      queue_row(32'h0000001B);
      queue_row(32'hA5A5A5F5);
      queue_row(32'h0000001B);
      queue_row(32'h8000001F);
      wait_for_idle();

      // smallest grid, empty and full
      apply_counts(6'd1, 6'd1);
      queue_row(32'h00000000);
      queue_row(32'hFFFFFFFF);
      wait_for_idle();

      // zero counts act as one
      apply_counts(6'd0, 6'd0);
      queue_row(32'hFFFFFFFE);
      wait_for_idle();

      // full-width grids: all border, then a wide enclosed region
      apply_counts(6'd2, 6'd32);
      queue_row(32'hFFFFFFFF);
      queue_row(32'h00000000);
      wait_for_idle();

      apply_counts(6'd4, 6'd32);
      queue_row(32'h00000000);
      queue_row(32'h7FFFFFFE);
      queue_row(32'h7FFFFFFE);
      queue_row(32'h00000000);
      wait_for_idle();

      apply_counts(6'd1, 6'd32);
      queue_row(32'hA5A5A5A5);
      wait_for_idle();

      // 3x3 with a closed cross around an open center
      apply_counts(6'd3, 6'd3);
      queue_row(32'h00000005);
      queue_row(32'hFFFFFFFA);
      queue_row(32'h00000005);
      wait_for_idle();

      // many small grids at once, the receiver's long hold-off lands here
      raw_cols = bcrf_pkg::CFG_W'($urandom_range(5, 32));
      apply_counts(6'd4, raw_cols);
      repeat (12) queue_grid(pick_shape(4, int'(raw_cols)), 4, int'(raw_cols));
      wait_for_idle();

      // counts above the limit act as the limit: one full serpentine grid
      apply_counts(6'd40, 6'd63);
      queue_grid(SHAPE_MAZE, MAX_ROWS, MAX_COLUMNS);
      wait_for_idle();

      while (pushed_count < ITEM_TARGET) begin
         // mostly small grids, a few large or out-of-range sizes
         k = $urandom_range(0, 99);
         if (k < 55) raw_rows = bcrf_pkg::CFG_W'($urandom_range(1, 8));
         else if (k < 80) raw_rows = bcrf_pkg::CFG_W'($urandom_range(9, 16));
         else if (k < 88) raw_rows = bcrf_pkg::CFG_W'($urandom_range(17, 31));
         else if (k < 93) raw_rows = 6'd32;
         else if (k < 96) raw_rows = 6'd0;
         else raw_rows = bcrf_pkg::CFG_W'($urandom_range(33, 63));
         k = $urandom_range(0, 99);
         if (k < 15) raw_cols = bcrf_pkg::CFG_W'($urandom_range(1, 4));
         else if (k < 70) raw_cols = bcrf_pkg::CFG_W'($urandom_range(5, 31));
         else if (k < 85) raw_cols = 6'd32;
         else if (k < 92) raw_cols = 6'd0;
         else raw_cols = bcrf_pkg::CFG_W'($urandom_range(33, 63));
         apply_counts(raw_rows, raw_cols);

         n          = effective_count(raw_rows, MAX_ROWS);
         cols       = effective_count(raw_cols, MAX_COLUMNS);
         grid_total = (n > 16) ? 1 : $urandom_range(1, 4);
         repeat (grid_total) queue_grid(pick_shape(n, cols), n, cols);

         // now and then a broken grid, cut short by the next register write
         if (n > 1 && $urandom_range(0, 7) == 0) begin
            partial = $urandom_range(1, n - 1);
            repeat (partial) queue_row($urandom);
         end
         wait_for_idle();
      end

      wait_for_idle();
      repeat (END_DRAIN) @(posedge clock);

      $display("run covered %0d requests in %0d grids over %0d size settings, %0d rows checked",
               accepted_count, grids_filled, settings_count, results_checked);
      $display("sizes ran from 1x1 to 32x32 with clamped counts, dropped partial grids, %0d mismatches",
               mismatch_count);
      if (mismatch_count == 0 && expected_rows.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
